FILE: rtl/cfpr_pkg.sv
`default_nettype none
package cfpr_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_OUT_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [7:0]  START_BYTE_RST  = 8'h00;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_FRM = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        logic [15:0] length;
        logic [1:0]  status;
    } t_result;

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v[15]) begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cfpr_cfg.sv
`default_nettype none
module cfpr_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [cfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cfpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cfpr_pkg::t_cfg                     o_cfg
);
    import cfpr_pkg::*;

    logic [7:0]  r_start_byte;
    logic [15:0] r_max_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_BYTE:  r_start_byte  <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.start_byte  = r_start_byte;
    assign o_cfg.max_payload = r_max_payload;

endmodule
`default_nettype wire

FILE: rtl/cfpr_parse.sv
`default_nettype none
module cfpr_parse (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_rx_timeout,
    input  wire cfpr_pkg::t_cfg i_cfg,
    output logic             o_res_valid,
    output cfpr_pkg::t_result o_res
);
    import cfpr_pkg::*;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_CMD     = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_LEN_HI  = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CRC_LO  = 7'b0100000,
        PH_CRC_HI  = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;

    logic [15:0] w_crc_next;
    logic [15:0] w_len_full;
    logic [15:0] w_count_inc;

    assign w_crc_next  = crc_feed(r_crc, i_rx_byte);
    assign w_len_full  = {i_rx_byte, r_len[7:0]};
    assign w_count_inc = r_count + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_count     = r_count;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_FRAME_END, payload_byte: 8'h00, command: r_cmd,
                        length: r_len, status: ST_OK};

        if (i_rx_timeout) begin
            if (r_phase != PH_HUNT) begin
                o_res_valid = 1'b1;
                o_res.status = ST_BAD_FRM;
                // Before the header is complete the command and length are unknown.
                if (r_phase == PH_CMD || r_phase == PH_LEN_LO || r_phase == PH_LEN_HI) begin
                    o_res.command = 8'h00;
                    o_res.length  = 16'h0000;
                end
            end
            n_phase  = PH_HUNT;
            n_count  = 16'h0000;
            n_crc    = CRC_INIT;
            n_crc_lo = 8'h00;
        end else begin
            unique case (r_phase)
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_crc   = w_crc_next;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_rx_byte};
                    n_crc   = w_crc_next;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = w_len_full;
                    n_crc   = w_crc_next;
                    n_count = 16'h0000;
                    if (w_len_full > i_cfg.max_payload) begin
                        o_res_valid  = 1'b1;
                        o_res.length = w_len_full;
                        o_res.status = ST_BAD_LEN;
                        n_phase  = PH_HUNT;
                        n_crc    = CRC_INIT;
                        n_crc_lo = 8'h00;
                    end else if (w_len_full == 16'h0000) begin
                        n_phase = PH_CRC_LO;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc   = w_crc_next;
                    n_count = w_count_inc;
                    if (w_count_inc >= r_len) begin
                        n_phase = PH_CRC_LO;
                    end
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = i_rx_byte;
                end
                PH_CRC_LO: begin
                    n_crc_lo = i_rx_byte;
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    o_res_valid  = 1'b1;
                    o_res.status = ({i_rx_byte, r_crc_lo} == r_crc) ? ST_OK : ST_CRC_ERR;
                    n_phase  = PH_HUNT;
                    n_count  = 16'h0000;
                    n_crc    = CRC_INIT;
                    n_crc_lo = 8'h00;
                end
                default: begin
                    if (i_rx_byte == i_cfg.start_byte) begin
                        n_cmd    = 8'h00;
                        n_len    = 16'h0000;
                        n_count  = 16'h0000;
                        n_crc    = CRC_INIT;
                        n_crc_lo = 8'h00;
                        n_phase  = PH_CMD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_cmd    <= 8'h00;
            r_len    <= 16'h0000;
            r_count  <= 16'h0000;
            r_crc    <= CRC_INIT;
            r_crc_lo <= 8'h00;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/crc16_framed_request_parser.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tdata: rx_byte; tuser: rx_timeout
// m_*       out        m_tvalid / m_tready   tdata: payload_byte, frame_command,
//                                            frame_length, end_status; tuser: out_kind
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item a cycle while m_* is not stalled: an input register feeds the frame state machine
// and CRC update, whose result is stored in the output register.
// The input register advances whenever the output register is empty or being taken,
// so a stall on m_* holds at most one item in each register before s_tready drops.
// Reset is synchronous and active low.
module crc16_framed_request_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  wire logic                            s_tuser,   // [0] rx_timeout
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] payload_byte, [15:8] frame_command, [31:16] frame_length,
    // [33:32] end_status, [39:34] zero
    output logic [cfpr_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic                                 m_tuser,   // [0] out_kind
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cfpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cfpr_pkg::*;

    t_cfg        w_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_tmo;
    logic        r_out_valid;
    t_result     r_out;
    logic        w_out_free;
    logic        w_step;
    logic        w_res_valid;
    t_result     w_res;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || m_tready;
    assign w_step      = r_in_valid && w_out_free;
    assign s_tready    = !r_in_valid || w_out_free;

    cfpr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cfpr_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_rx_byte    (r_in_byte),
        .i_rx_timeout (r_in_tmo),
        .i_cfg        (w_cfg),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
            r_in_tmo  <= s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.kind;
    assign m_tdata  = {6'b000000, r_out.status, r_out.length, r_out.command,
                       r_out.payload_byte};

endmodule
`default_nettype wire

FILE: rtl/cfpr_checker.sv
`default_nettype none
module cfpr_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [cfpr_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  wire logic                            m_tuser
);
    import cfpr_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // A free output side never blocks the input side.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    // Payload transfers carry ok status; frame ends carry a zero payload byte.
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == KIND_PAYLOAD) |-> m_tdata[33:32] == ST_OK)
        else $error("payload transfer with nonzero status");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == KIND_FRAME_END) |-> m_tdata[7:0] == 8'h00)
        else $error("frame end with nonzero payload byte");

endmodule

bind crc16_framed_request_parser cfpr_checker u_cfpr_checker (.*);
`default_nettype wire
